// ===== rtl/pij_pkg.sv =====
package pij_pkg;

    localparam int PIX_W     = 12;
    localparam int DEPTH_W   = 32;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_LANES = 3;
    localparam int DIV_STEPS = 32;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SKEW     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_OFFSET_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_Y  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_OFFSET_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_SKEW   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 4'd7;

    localparam logic signed [DATA_W-1:0] ONE_Q24     = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] ONE_Q16     = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q16 = 32'shFFFF_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN     = 32'sh8000_0000;

    // divider lanes
    localparam int LANE_M1 = 0;
    localparam int LANE_X  = 1;
    localparam int LANE_Y  = 2;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_col;
        logic [PIX_W-1:0]   pixel_row;
        logic [DEPTH_W-1:0] depth;
    } pij_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] ju_vx;
        logic signed [DATA_W-1:0] ju_vy;
        logic signed [DATA_W-1:0] ju_vz;
        logic signed [DATA_W-1:0] ju_wx;
        logic signed [DATA_W-1:0] ju_wy;
        logic signed [DATA_W-1:0] ju_wz;
        logic signed [DATA_W-1:0] jv_vx;
        logic signed [DATA_W-1:0] jv_vy;
        logic signed [DATA_W-1:0] jv_vz;
        logic signed [DATA_W-1:0] jv_wx;
        logic signed [DATA_W-1:0] jv_wy;
        logic signed [DATA_W-1:0] jv_wz;
    } pij_out_t;

    // per-item control that rides along the divider
    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] nz;
        logic [NUM_LANES-1:0] big;
        logic                 zzero;
        logic [DEPTH_W-1:0]   z;
    } pij_dflag_t;

    // inner matrix entries that do not need the divider
    typedef struct packed {
        logic signed [DATA_W-1:0] xy;
        logic signed [DATA_W-1:0] nxx;
        logic signed [DATA_W-1:0] yy;
        logic signed [DATA_W-1:0] nxy;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] nx;
    } pij_ent_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 66'sd2147483647)
            r = SAT_MAX;
        else if (v < -66'sd2147483648)
            r = SAT_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // round half up at bit s, then saturate
    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [65:0] v,
                                                         input int unsigned s);
        logic signed [65:0] t;
        t = (v + (66'sd1 <<< (s - 1))) >>> s;
        return sat32(t);
    endfunction

    // quotient magnitude to signed Q16.16 with the zero and overflow cases
    function automatic logic signed [DATA_W-1:0] qfin(input logic [DATA_W-1:0] q,
                                                      input logic neg, input logic nz,
                                                      input logic big, input logic zzero);
        logic signed [DATA_W-1:0] r;
        if (zzero)
            r = nz ? (neg ? SAT_MIN : SAT_MAX) : '0;
        else if (big)
            r = neg ? SAT_MIN : SAT_MAX;
        else if (neg)
            r = (q > 32'h8000_0000) ? SAT_MIN : $signed(~q + 32'd1);
        else
            r = (q > 32'h7FFF_FFFF) ? SAT_MAX : $signed(q);
        return r;
    endfunction

endpackage

// ===== rtl/point_image_jacobian.sv =====
// Point-feature image Jacobian. One point (column, row, depth) may be started in every
// clock cycle; busy never rises. The 2x6 result appears on jac with done high for one
// cycle; the receiver cannot hold it off. The pipeline holds the three parallel
// restoring dividers for -1/z, x/z and y/z, one stage to set up the dividends and one
// quotient bit per stage over 32 stages, plus three stages to normalize the pixel and
// three to finish the focal products and rounding. Configuration writes take effect at
// once and belong only between items.
module point_image_jacobian
    import pij_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pij_in_t              point,
    output logic                 done,
    output pij_out_t             jac,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int UB = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
    localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((33'd1 << UB) - 33'd1);

    logic signed [DATA_W-1:0] inv_scale_x_reg, inv_skew_reg, inv_offset_x_reg;
    logic signed [DATA_W-1:0] inv_scale_y_reg, inv_offset_y_reg;
    logic signed [DATA_W-1:0] focal_x_reg, focal_skew_reg, focal_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_x_reg  <= ONE_Q24;
            inv_skew_reg     <= '0;
            inv_offset_x_reg <= '0;
            inv_scale_y_reg  <= ONE_Q24;
            inv_offset_y_reg <= '0;
            focal_x_reg      <= ONE_Q16;
            focal_skew_reg   <= '0;
            focal_y_reg      <= ONE_Q16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_INV_SCALE_X:  inv_scale_x_reg  <= $signed(cfg_data);
                REG_INV_SKEW:     inv_skew_reg     <= $signed(cfg_data);
                REG_INV_OFFSET_X: inv_offset_x_reg <= $signed(cfg_data);
                REG_INV_SCALE_Y:  inv_scale_y_reg  <= $signed(cfg_data);
                REG_INV_OFFSET_Y: inv_offset_y_reg <= $signed(cfg_data);
                REG_FOCAL_X:      focal_x_reg      <= $signed(cfg_data);
                REG_FOCAL_SKEW:   focal_skew_reg   <= $signed(cfg_data);
                REG_FOCAL_Y:      focal_y_reg      <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: capture
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_u_reg, s1_v_reg;
    logic [DEPTH_W-1:0] s1_z_reg;

    // ---------------- stage 2: intrinsics products
    logic                     s2_valid_reg;
    logic signed [PIX_W+32:0] s2_au_reg, s2_av_reg, s2_bv_reg;
    logic [DEPTH_W-1:0]       s2_z_reg;

    // ---------------- stage 3: normalized point
    logic                     s3_valid_reg;
    logic signed [DATA_W-1:0] s3_x_reg, s3_y_reg;
    logic [DEPTH_W-1:0]       s3_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_u_reg  <= point.pixel_col & COORD_MASK;
        s1_v_reg  <= point.pixel_row & COORD_MASK;
        s1_z_reg  <= point.depth;
        s2_au_reg <= (PIX_W+33)'(inv_scale_x_reg) * $signed({1'b0, s1_u_reg});
        s2_av_reg <= (PIX_W+33)'(inv_skew_reg) * $signed({1'b0, s1_v_reg});
        s2_bv_reg <= (PIX_W+33)'(inv_scale_y_reg) * $signed({1'b0, s1_v_reg});
        s2_z_reg  <= s1_z_reg;
        s3_x_reg  <= rnd_sat(66'(s2_au_reg) + 66'(s2_av_reg) + 66'(inv_offset_x_reg), 8);
        s3_y_reg  <= rnd_sat(66'(s2_bv_reg) + 66'(inv_offset_y_reg), 8);
        s3_z_reg  <= s2_z_reg;
    end

    // ---------------- divider front: products and dividend setup
    logic signed [DATA_W-1:0] numer [NUM_LANES];
    logic [DATA_W-1:0]        mag   [NUM_LANES];
    logic [47:0]              dvd   [NUM_LANES];
    pij_dflag_t               flag_in;

    always_comb
    begin
        numer[LANE_M1] = NEG_ONE_Q16;
        numer[LANE_X]  = s3_x_reg;
        numer[LANE_Y]  = s3_y_reg;
        flag_in.zzero  = (s3_z_reg == '0);
        flag_in.z      = s3_z_reg;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            mag[k]          = numer[k][DATA_W-1] ? (~numer[k] + 32'd1) : numer[k];
            dvd[k]          = {mag[k], 16'h0000} + {17'h0, s3_z_reg[DEPTH_W-1:1]};
            flag_in.neg[k]  = numer[k][DATA_W-1];
            flag_in.nz[k]   = (numer[k] != '0);
            flag_in.big[k]  = ({16'h0000, dvd[k][47:32]} >= s3_z_reg);
        end
    end

    logic                     dv_valid_reg [DIV_STEPS+1];
    pij_dflag_t               dv_flag_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0]        dv_rem_reg   [DIV_STEPS+1][NUM_LANES];
    logic [DATA_W-1:0]        dv_q_reg     [DIV_STEPS+1][NUM_LANES];
    pij_ent_t                 ent_reg      [1:DIV_STEPS];
    logic signed [63:0]       p_xy_reg, p_xx_reg, p_yy_reg;
    logic signed [DATA_W-1:0] p_x_reg, p_y_reg;
    pij_ent_t                 ent_in;

    // one quotient bit per stage
    logic [DATA_W:0]   trial    [DIV_STEPS][NUM_LANES];
    logic              take     [DIV_STEPS][NUM_LANES];
    logic [DATA_W-1:0] rem_next [DIV_STEPS][NUM_LANES];
    logic [DATA_W-1:0] q_next   [DIV_STEPS][NUM_LANES];

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                trial[j][k]    = {dv_rem_reg[j][k], dv_q_reg[j][k][DATA_W-1]};
                take[j][k]     = (trial[j][k] >= {1'b0, dv_flag_reg[j].z});
                rem_next[j][k] = take[j][k] ? DATA_W'(trial[j][k] - {1'b0, dv_flag_reg[j].z})
                                            : trial[j][k][DATA_W-1:0];
                q_next[j][k]   = {dv_q_reg[j][k][DATA_W-2:0], take[j][k]};
            end
        end
    end

    always_comb
    begin
        ent_in.xy  = rnd_sat(66'(p_xy_reg), 16);
        ent_in.nxx = rnd_sat(-(66'sd4294967296 + 66'(p_xx_reg)), 16);
        ent_in.yy  = rnd_sat(66'sd4294967296 + 66'(p_yy_reg), 16);
        ent_in.nxy = rnd_sat(-66'(p_xy_reg), 16);
        ent_in.y   = p_y_reg;
        ent_in.nx  = (p_x_reg == SAT_MIN) ? SAT_MAX : -p_x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
                dv_valid_reg[j] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s3_valid_reg;
            for (int j = 1; j <= DIV_STEPS; j++)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p_xy_reg       <= s3_x_reg * s3_y_reg;
        p_xx_reg       <= s3_x_reg * s3_x_reg;
        p_yy_reg       <= s3_y_reg * s3_y_reg;
        p_x_reg        <= s3_x_reg;
        p_y_reg        <= s3_y_reg;
        dv_flag_reg[0] <= flag_in;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            dv_rem_reg[0][k] <= {16'h0000, dvd[k][47:32]};
            dv_q_reg[0][k]   <= dvd[k][31:0];
        end
        ent_reg[1] <= ent_in;
        for (int j = 2; j <= DIV_STEPS; j++)
            ent_reg[j] <= ent_reg[j-1];
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dv_flag_reg[j] <= dv_flag_reg[j-1];
            for (int k = 0; k < NUM_LANES; k++)
            begin
                dv_rem_reg[j][k] <= rem_next[j-1][k];
                dv_q_reg[j][k]   <= q_next[j-1][k];
            end
        end
    end

    // ---------------- quotient finish
    logic                     fin_valid_reg;
    logic signed [DATA_W-1:0] fin_q_reg [NUM_LANES];
    pij_ent_t                 fin_ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else
            fin_valid_reg <= dv_valid_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_LANES; k++)
            fin_q_reg[k] <= qfin(dv_q_reg[DIV_STEPS][k], dv_flag_reg[DIV_STEPS].neg[k],
                                 dv_flag_reg[DIV_STEPS].nz[k], dv_flag_reg[DIV_STEPS].big[k],
                                 dv_flag_reg[DIV_STEPS].zzero);
        fin_ent_reg <= ent_reg[DIV_STEPS];
    end

    // ---------------- focal products
    logic signed [DATA_W-1:0] row0 [6];
    logic signed [DATA_W-1:0] row1 [6];
    logic                     mp_valid_reg;
    logic signed [63:0]       mp_a_reg [6];
    logic signed [63:0]       mp_b_reg [6];
    logic signed [63:0]       mp_c_reg [6];

    always_comb
    begin
        row0[0] = fin_q_reg[LANE_M1];
        row0[1] = '0;
        row0[2] = fin_q_reg[LANE_X];
        row0[3] = fin_ent_reg.xy;
        row0[4] = fin_ent_reg.nxx;
        row0[5] = fin_ent_reg.y;
        row1[0] = '0;
        row1[1] = fin_q_reg[LANE_M1];
        row1[2] = fin_q_reg[LANE_Y];
        row1[3] = fin_ent_reg.yy;
        row1[4] = fin_ent_reg.nxy;
        row1[5] = fin_ent_reg.nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mp_valid_reg <= 1'b0;
        else
            mp_valid_reg <= fin_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            mp_a_reg[j] <= focal_x_reg * row0[j];
            mp_b_reg[j] <= focal_skew_reg * row1[j];
            mp_c_reg[j] <= focal_y_reg * row1[j];
        end
    end

    // ---------------- sum, round, output beat
    logic signed [DATA_W-1:0] ju [6];
    logic signed [DATA_W-1:0] jv [6];
    logic                     done_reg;
    pij_out_t                 jac_reg;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            ju[j] = rnd_sat(66'(mp_a_reg[j]) + 66'(mp_b_reg[j]), 16);
            jv[j] = rnd_sat(66'(mp_c_reg[j]), 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        jac_reg.ju_vx <= ju[0];
        jac_reg.ju_vy <= ju[1];
        jac_reg.ju_vz <= ju[2];
        jac_reg.ju_wx <= ju[3];
        jac_reg.ju_wy <= ju[4];
        jac_reg.ju_wz <= ju[5];
        jac_reg.jv_vx <= jv[0];
        jac_reg.jv_vy <= jv[1];
        jac_reg.jv_vz <= jv[2];
        jac_reg.jv_wx <= jv[3];
        jac_reg.jv_wy <= jv[4];
        jac_reg.jv_wz <= jv[5];
    end

    assign done = done_reg;
    assign jac  = jac_reg;

    // the v row has no linear x term
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (jac.jv_vx == '0))
        else $error("jv_vx not zero");

    // a divider lane that did not overflow keeps its remainder below the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_STEPS] && !dv_flag_reg[DIV_STEPS].zzero
         && (dv_flag_reg[DIV_STEPS].big == '0))
        |-> ((dv_rem_reg[DIV_STEPS][LANE_M1] < dv_flag_reg[DIV_STEPS].z)
             && (dv_rem_reg[DIV_STEPS][LANE_X] < dv_flag_reg[DIV_STEPS].z)
             && (dv_rem_reg[DIV_STEPS][LANE_Y] < dv_flag_reg[DIV_STEPS].z)))
        else $error("divider remainder out of range");

    // zero depth drives -1/z to the negative limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_STEPS] && dv_flag_reg[DIV_STEPS].zzero)
        |=> (fin_q_reg[LANE_M1] == SAT_MIN))
        else $error("zero depth reciprocal not saturated");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pij_pkg::*;

    class jacobian_board;
        pij_out_t pending[$];
        int       errors;

        logic signed [31:0] inv_sx, inv_sk, inv_ox, inv_sy, inv_oy, f_x, f_s, f_y;

        function void reset_regs();
            inv_sx = ONE_Q24;
            inv_sk = '0;
            inv_ox = '0;
            inv_sy = ONE_Q24;
            inv_oy = '0;
            f_x    = ONE_Q16;
            f_s    = '0;
            f_y    = ONE_Q16;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_INV_SCALE_X:  inv_sx = d;
                REG_INV_SKEW:     inv_sk = d;
                REG_INV_OFFSET_X: inv_ox = d;
                REG_INV_SCALE_Y:  inv_sy = d;
                REG_INV_OFFSET_Y: inv_oy = d;
                REG_FOCAL_X:      f_x = d;
                REG_FOCAL_SKEW:   f_s = d;
                REG_FOCAL_Y:      f_y = d;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp(logic signed [127:0] v);
            if (v > 128'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -128'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // round half up then clamp
        function logic signed [31:0] round_q(logic signed [127:0] v, int s);
            return clamp((v + (128'sd1 <<< (s - 1))) >>> s);
        endfunction

        function logic signed [31:0] quot(logic signed [31:0] n, logic [31:0] z);
            logic signed [127:0] num;
            logic [127:0]        mag, q;
            if (z == 0)
                return n > 0 ? 32'sh7FFF_FFFF : (n < 0 ? 32'sh8000_0000 : 32'sh0);
            num = 128'(n) <<< 16;
            mag = num < 0 ? -num : num;
            q = (mag + 128'(z >> 1)) / 128'(z);
            if (num < 0)
                return clamp(-$signed(q));
            return clamp($signed(q));
        endfunction

        function void note_point(pij_in_t p);
            logic signed [127:0] xw, yw, xs, ys, sum, one, lim;
            logic signed [31:0]  r0[6], r1[6], o0[6], o1[6];
            pij_out_t            e;
            xw = 128'(inv_sx) * $signed({1'b0, p.pixel_col})
               + 128'(inv_sk) * $signed({1'b0, p.pixel_row}) + 128'(inv_ox);
            yw = 128'(inv_sy) * $signed({1'b0, p.pixel_row}) + 128'(inv_oy);
            xs = 128'(round_q(xw, 8));
            ys = 128'(round_q(yw, 8));
            one = 128'sd1 <<< 32;
            r0[0] = quot(NEG_ONE_Q16, p.depth);
            r0[1] = '0;
            r0[2] = quot(xs[31:0], p.depth);
            r0[3] = round_q(xs * ys, 16);
            r0[4] = round_q(-(one + xs * xs), 16);
            r0[5] = ys[31:0];
            r1[0] = '0;
            r1[1] = r0[0];
            r1[2] = quot(ys[31:0], p.depth);
            r1[3] = round_q(one + ys * ys, 16);
            r1[4] = round_q(-(xs * ys), 16);
            r1[5] = clamp(-xs);
            lim = 128'sd1 <<< 63;
            for (int j = 0; j < 6; j++)
            begin
                sum = 128'(f_x) * 128'(r0[j]) + 128'(f_s) * 128'(r1[j]);
                if (sum >= lim)
                    sum = lim - 1;
                else if (sum < -lim)
                    sum = -lim;
                o0[j] = round_q(sum, 16);
                o1[j] = round_q(128'(f_y) * 128'(r1[j]), 16);
            end
            e = {o0[0], o0[1], o0[2], o0[3], o0[4], o0[5],
                 o1[0], o1[1], o1[2], o1[3], o1[4], o1[5]};
            pending = {pending, e};
        endfunction

        task mismatch(string what, logic [31:0] g, logic [31:0] w);
            $display("MISMATCH %s: got %h want %h at %0t", what, g, w, $realtime);
            errors++;
        endtask

        task check_matrix(pij_out_t got);
            pij_out_t   w;
            logic [31:0] gv, wv;
            if (pending.size() == 0)
            begin
                mismatch("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            for (int k = 0; k < 12; k++)
            begin
                gv = got[383 - 32 * k -: 32];
                wv = w[383 - 32 * k -: 32];
                if (gv !== wv)
                    mismatch($sformatf("entry %0d", k), gv, wv);
            end
        endtask
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    pij_in_t              point = '0;
    logic                 done;
    pij_out_t             jac;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    jacobian_board        sb = new();
    int                   gap_pct = 29;

    point_image_jacobian u_top (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_matrix(jac);

    task automatic send_point(logic [11:0] u, logic [11:0] v, logic [31:0] z);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        point <= '{pixel_col: u, pixel_row: v, depth: z};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_point('{pixel_col: u, pixel_row: v, depth: z});
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    // write enable stays up across a burst; the caller drops it afterwards
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= d;
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_depth();
        case ($urandom_range(5))
            0: return 0;
            1: return $urandom;
            2: return $urandom_range(32'h0004_0000, 32'h0001_0000);
            default: return $urandom_range(32'h0100_0000, 32'h0000_0100);
        endcase
    endfunction

    task automatic load_camera(int mode);
        logic [31:0] v[8];
        case (mode)
            0: v = '{32'h0100_0000, 0, 0, 32'h0100_0000, 0, 32'h0001_0000, 0, 32'h0001_0000};
            1: v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2: v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            3: begin
                // realistic camera: f ~ 500 px, center ~ (320,240)
                v[0] = 32'd33554 + $urandom_range(2000);
                v[1] = $urandom_range(200) - 100;
                v[2] = -32'sd10737418 - $urandom_range(100000);
                v[3] = 32'd33554 + $urandom_range(2000);
                v[4] = -32'sd8053063 - $urandom_range(100000);
                v[5] = 32'd32768000 + $urandom_range(65536000);
                v[6] = $urandom_range(65536);
                v[7] = 32'd32768000 + $urandom_range(65536000);
            end
            default: foreach (v[i]) v[i] = $urandom;
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(i[CFG_IDX_W-1:0], v[i]);
        write_reg(4'd9, $urandom);
        cfg_we <= 0;
    endtask

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb.reset_regs();
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed points at reset intrinsics
        send_point(0, 0, 32'h0001_0000);
        send_point(12'hFFF, 12'hFFF, 32'h0001_0000);
        send_point(12'hFFF, 0, 0);
        send_point(0, 12'hFFF, 0);
        send_point(0, 0, 0);
        send_point(12'hAAA, 12'h555, 32'hFFFF_FFFF);
        send_point(12'h555, 12'hAAA, 32'h0000_0001);
        send_point(100, 200, 32'h0000_8000);
        drain();
        load_camera(1);
        send_point(12'hFFF, 12'hFFF, 32'h0000_0001);
        send_point(0, 0, 0);
        send_point(1, 1, 32'hFFFF_FFFF);
        drain();
        load_camera(2);
        send_point(12'hFFF, 12'hFFF, 0);
        send_point(0, 0, 32'h0001_0000);
        send_point(7, 9, 32'h8000_0000);
        drain();
        load_camera(3);
        send_point(320, 240, 32'h0002_0000);
        send_point(0, 0, 0);
        send_point(639, 479, 32'h0010_0000);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            load_camera(ph % 5 == 0 ? 3 : ph % 5);
            gap_pct = (ph == 4) ? 0 : 29;
            for (int n = 0; n < 48; n++)
                send_point(12'($urandom), 12'($urandom), rnd_depth());
        end
        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
